FILE: rtl/midi_event_translator_defines.svh
// Assertion macros for the MIDI event translator checker.
// No dependencies.
`ifndef MIDI_EVENT_TRANSLATOR_DEFINES_SVH
`define MIDI_EVENT_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MEVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("midi_event_translator assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MEVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("midi_event_translator assertion failed");

`endif

FILE: rtl/mevt_pkg.sv
// Shared types, codes and the controller command table for the MIDI event translator.
// No dependencies.
package mevt_pkg;

  typedef enum logic [2:0] {
    EV_NOTE_ON   = 3'd0,
    EV_NOTE_OFF  = 3'd1,
    EV_KEY_PRES  = 3'd2,
    EV_CTRL      = 3'd3,
    EV_PROGRAM   = 3'd4,
    EV_CHAN_PRES = 3'd5,
    EV_PITCH     = 3'd6,
    EV_OTHER     = 3'd7
  } event_kind_t;

  typedef enum logic [1:0] {
    SEL_NONE   = 2'd0,
    SEL_REG    = 2'd1,
    SEL_NONREG = 2'd2
  } sel_kind_t;

  typedef struct packed {
    sel_kind_t  kind;
    logic [6:0] high;
    logic [6:0] low;
  } sel_entry_t;

  typedef struct packed {
    logic       en;
    sel_kind_t  kind;
    logic       set_high;
    logic [6:0] value;
  } sel_update_t;

  localparam int ChannelWidth = 4;
  localparam int Channels     = 16;
  localparam int KindWidth    = 5;
  localparam int ParamWidth   = 15;

  // controller numbers
  localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CC_DATA_LOW   = 7'd38;
  localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
  localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
  localparam logic [6:0] CC_RPN_LSB    = 7'd100;
  localparam logic [6:0] CC_RPN_MSB    = 7'd101;

  // registered parameter numbers (low byte, high byte zero)
  localparam logic [6:0] RPN_PITCH_RANGE = 7'd0;
  localparam logic [6:0] RPN_FINE_TUNE   = 7'd1;
  localparam logic [6:0] RPN_COARSE_TUNE = 7'd2;

  // command codes
  localparam logic [4:0] CMD_NOTE        = 5'd0;
  localparam logic [4:0] CMD_KEYPRES     = 5'd1;
  localparam logic [4:0] CMD_CONTROL     = 5'd2;
  localparam logic [4:0] CMD_PROGRAM     = 5'd3;
  localparam logic [4:0] CMD_CHANPRES    = 5'd4;
  localparam logic [4:0] CMD_PITCH       = 5'd5;
  localparam logic [4:0] CMD_PITCHRANGE  = 5'd6;
  localparam logic [4:0] CMD_FINETUNE    = 5'd7;
  localparam logic [4:0] CMD_COARSETUNE  = 5'd8;
  localparam logic [4:0] CMD_BANK        = 5'd9;
  localparam logic [4:0] CMD_MODULATION  = 5'd10;
  localparam logic [4:0] CMD_PORTA_TIME  = 5'd11;
  localparam logic [4:0] CMD_VOLUME      = 5'd12;
  localparam logic [4:0] CMD_PAN         = 5'd13;
  localparam logic [4:0] CMD_EXPRESSION  = 5'd14;
  localparam logic [4:0] CMD_BANK_LOW    = 5'd15;
  localparam logic [4:0] CMD_SUSTAIN     = 5'd16;
  localparam logic [4:0] CMD_PORTAMENTO  = 5'd17;
  localparam logic [4:0] CMD_SOSTENUTO   = 5'd18;
  localparam logic [4:0] CMD_SOFT        = 5'd19;
  localparam logic [4:0] CMD_RESONANCE   = 5'd20;
  localparam logic [4:0] CMD_RELEASE     = 5'd21;
  localparam logic [4:0] CMD_ATTACK      = 5'd22;
  localparam logic [4:0] CMD_CUTOFF      = 5'd23;
  localparam logic [4:0] CMD_DECAY       = 5'd24;
  localparam logic [4:0] CMD_PORTA_NOTE  = 5'd25;
  localparam logic [4:0] CMD_REVERB      = 5'd26;
  localparam logic [4:0] CMD_CHORUS      = 5'd27;
  localparam logic [4:0] CMD_SOUND_OFF   = 5'd28;
  localparam logic [4:0] CMD_RESET_CTRL  = 5'd29;
  localparam logic [4:0] CMD_NOTES_OFF   = 5'd30;

  // Dedicated command for a controller; CMD_NOTE means none (generic control).
  function automatic logic [4:0] cc_command(input logic [6:0] cc);
    logic [4:0] cmd;
    case (cc)
      7'd0:    cmd = CMD_BANK;
      7'd1:    cmd = CMD_MODULATION;
      7'd5:    cmd = CMD_PORTA_TIME;
      7'd7:    cmd = CMD_VOLUME;
      7'd10:   cmd = CMD_PAN;
      7'd11:   cmd = CMD_EXPRESSION;
      7'd32:   cmd = CMD_BANK_LOW;
      7'd64:   cmd = CMD_SUSTAIN;
      7'd65:   cmd = CMD_PORTAMENTO;
      7'd66:   cmd = CMD_SOSTENUTO;
      7'd67:   cmd = CMD_SOFT;
      7'd71:   cmd = CMD_RESONANCE;
      7'd72:   cmd = CMD_RELEASE;
      7'd73:   cmd = CMD_ATTACK;
      7'd74:   cmd = CMD_CUTOFF;
      7'd75:   cmd = CMD_DECAY;
      7'd84:   cmd = CMD_PORTA_NOTE;
      7'd91:   cmd = CMD_REVERB;
      7'd93:   cmd = CMD_CHORUS;
      7'd120:  cmd = CMD_SOUND_OFF;
      7'd121:  cmd = CMD_RESET_CTRL;
      7'd123:  cmd = CMD_NOTES_OFF;
      default: cmd = CMD_NOTE;
    endcase
    return cmd;
  endfunction

endpackage

FILE: rtl/mevt_sel_store.sv
// Per-channel parameter selection store: kind plus high and low bytes.
// Depends on mevt_pkg.
module mevt_sel_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mevt_pkg::ChannelWidth-1:0] ch,
  input  mevt_pkg::sel_update_t            upd,
  output mevt_pkg::sel_entry_t             entry
);

  mevt_pkg::sel_entry_t sel [mevt_pkg::Channels];

  assign entry = sel[ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mevt_pkg::Channels; i++) begin
        sel[i] <= '{kind: mevt_pkg::SEL_NONE, high: 7'd0, low: 7'd0};
      end
    end else if (upd.en) begin
      sel[ch].kind <= upd.kind;
      if (upd.set_high) begin
        sel[ch].high <= upd.value;
      end else begin
        sel[ch].low <= upd.value;
      end
    end
  end

endmodule

FILE: rtl/mevt_decode.sv
// Event decode: maps one event and its channel's selection to a command and a store update.
// Depends on mevt_pkg.
module mevt_decode (
  input  logic [2:0]                        event_kind,
  input  logic [13:0]                       data_a,
  input  logic [6:0]                        data_b,
  input  mevt_pkg::sel_entry_t              entry,
  output logic                              emit,
  output logic [mevt_pkg::KindWidth-1:0]    cmd_kind,
  output logic [mevt_pkg::ParamWidth-1:0]   cmd_param,
  output mevt_pkg::sel_update_t             upd
);

  logic [6:0] a;
  logic [4:0] cc_cmd;
  logic [14:0] pair;
  logic [14:0] b_only;
  logic [14:0] a_only;

  assign a      = data_a[6:0];
  assign cc_cmd = mevt_pkg::cc_command(a);
  assign pair   = {data_b, 1'b0, a};
  assign b_only = {8'd0, data_b};
  assign a_only = {8'd0, a};

  always_comb begin
    emit      = 1'b0;
    cmd_kind  = mevt_pkg::CMD_NOTE;
    cmd_param = '0;
    upd       = '{en: 1'b0, kind: mevt_pkg::SEL_NONE, set_high: 1'b0, value: data_b};
    case (mevt_pkg::event_kind_t'(event_kind))
      mevt_pkg::EV_NOTE_ON: begin
        emit      = 1'b1;
        cmd_param = pair;
      end
      mevt_pkg::EV_NOTE_OFF: begin
        emit      = 1'b1;
        cmd_param = a_only;
      end
      mevt_pkg::EV_KEY_PRES: begin
        emit      = 1'b1;
        cmd_kind  = mevt_pkg::CMD_KEYPRES;
        cmd_param = pair;
      end
      mevt_pkg::EV_CTRL: begin
        if (a == mevt_pkg::CC_RPN_MSB || a == mevt_pkg::CC_RPN_LSB ||
            a == mevt_pkg::CC_NRPN_MSB || a == mevt_pkg::CC_NRPN_LSB) begin
          upd.en       = 1'b1;
          upd.kind     = (a >= mevt_pkg::CC_RPN_LSB) ? mevt_pkg::SEL_REG
                                                     : mevt_pkg::SEL_NONREG;
          upd.set_high = (a == mevt_pkg::CC_RPN_MSB) || (a == mevt_pkg::CC_NRPN_MSB);
        end else if (a == mevt_pkg::CC_DATA_ENTRY) begin
          if (entry.kind == mevt_pkg::SEL_REG && entry.high == 7'd0) begin
            cmd_param = b_only;
            if (entry.low == mevt_pkg::RPN_PITCH_RANGE) begin
              emit     = 1'b1;
              cmd_kind = mevt_pkg::CMD_PITCHRANGE;
            end else if (entry.low == mevt_pkg::RPN_FINE_TUNE) begin
              emit     = 1'b1;
              cmd_kind = mevt_pkg::CMD_FINETUNE;
            end else if (entry.low == mevt_pkg::RPN_COARSE_TUNE) begin
              emit     = 1'b1;
              cmd_kind = mevt_pkg::CMD_COARSETUNE;
            end
          end
        end else if (a != mevt_pkg::CC_DATA_LOW) begin
          emit = 1'b1;
          if (cc_cmd != mevt_pkg::CMD_NOTE) begin
            cmd_kind  = cc_cmd;
            cmd_param = b_only;
          end else begin
            cmd_kind  = mevt_pkg::CMD_CONTROL;
            cmd_param = pair;
          end
        end
      end
      mevt_pkg::EV_PROGRAM: begin
        emit      = 1'b1;
        cmd_kind  = mevt_pkg::CMD_PROGRAM;
        cmd_param = a_only;
      end
      mevt_pkg::EV_CHAN_PRES: begin
        emit      = 1'b1;
        cmd_kind  = mevt_pkg::CMD_CHANPRES;
        cmd_param = a_only;
      end
      mevt_pkg::EV_PITCH: begin
        emit      = 1'b1;
        cmd_kind  = mevt_pkg::CMD_PITCH;
        cmd_param = {1'b0, data_a};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/midi_event_translator.sv
// MIDI event translator top level: input register, decode with selection store, result register.
// Result path: input register, then decode, then result register, which holds while the output is stalled.
// Throughput: one item per cycle while the output is not stalled; an item that gives no result is never held.
// The per-channel selection store is read and written in the decode stage, so a
// selection is seen by the very next item. Reset clears all 16 entries and both stages.
// Depends on mevt_pkg, mevt_sel_store, mevt_decode.
module midi_event_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  event_kind,
  input  logic [3:0]  channel,
  input  logic [13:0] data_a,
  input  logic [6:0]  data_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  command_kind,
  output logic [14:0] command_param
);

  logic        s1_valid;
  logic [2:0]  s1_kind;
  logic [3:0]  s1_channel;
  logic [13:0] s1_data_a;
  logic [6:0]  s1_data_b;

  logic                  dec_emit;
  logic [4:0]            dec_kind;
  logic [14:0]           dec_param;
  mevt_pkg::sel_update_t dec_upd;
  mevt_pkg::sel_update_t store_upd;
  mevt_pkg::sel_entry_t  entry;

  logic out_free;
  logic s1_go;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!dec_emit || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_comb begin
    store_upd    = dec_upd;
    store_upd.en = dec_upd.en && s1_go;
  end

  mevt_sel_store u_store (
    .clk   (clk),
    .rst   (rst),
    .ch    (s1_channel),
    .upd   (store_upd),
    .entry (entry)
  );

  mevt_decode u_decode (
    .event_kind (s1_kind),
    .data_a     (s1_data_a),
    .data_b     (s1_data_b),
    .entry      (entry),
    .emit       (dec_emit),
    .cmd_kind   (dec_kind),
    .cmd_param  (dec_param),
    .upd        (dec_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid && dec_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind    <= event_kind;
      s1_channel <= channel;
      s1_data_a  <= data_a;
      s1_data_b  <= data_b;
    end
    if (out_free && s1_valid && dec_emit) begin
      command_kind  <= dec_kind;
      command_param <= dec_param;
    end
  end

endmodule

FILE: rtl/mevt_checker.sv
// Port-level checker for the MIDI event translator, bound to the top level.
// Depends on midi_event_translator_defines.svh, mevt_pkg and midi_event_translator.
`include "midi_event_translator_defines.svh"

module mevt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  command_kind,
  input logic [14:0] command_param
);

  logic stalled;
  logic byte_cmd;

  assign stalled  = out_valid && !out_ready;
  assign byte_cmd = (command_kind >= mevt_pkg::CMD_PROGRAM) &&
                    (command_kind != mevt_pkg::CMD_PITCH);

  `MEVT_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable({command_kind, command_param}))
  `MEVT_ASSERT_NOW(a_empty_out_ready, !out_valid, in_ready)
  `MEVT_ASSERT_NOW(a_kind_range, out_valid, command_kind <= mevt_pkg::CMD_NOTES_OFF)
  `MEVT_ASSERT_NOW(a_byte_param, out_valid && byte_cmd, command_param[14:7] == 8'd0)
  `MEVT_ASSERT_NOW(a_reset_clear, $past(rst), !out_valid)

endmodule

bind midi_event_translator mevt_checker u_mevt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .command_kind  (command_kind),
  .command_param (command_param)
);

FILE: test/testbench.sv
// Self-checking bench for midi_event_translator: predicts the synth command of every
// accepted MIDI event, tracking per-channel parameter selection, and checks results in order.
// Depends on mevt_pkg and the midi_event_translator RTL.
module testbench;

  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;

  class midi_command_checker;
    typedef struct packed {
      logic [4:0]  kind;
      logic [14:0] param;
    } synth_cmd_t;

    mevt_pkg::sel_kind_t sel_kind [mevt_pkg::Channels];
    logic [6:0]          sel_high [mevt_pkg::Channels];
    logic [6:0]          sel_low  [mevt_pkg::Channels];
    synth_cmd_t          expected_cmds[$];
    int                  errors;

    function new();
      for (int i = 0; i < mevt_pkg::Channels; i++) begin
        sel_kind[i] = mevt_pkg::SEL_NONE;
        sel_high[i] = '0;
        sel_low[i]  = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void queue_cmd(input logic [4:0] kind, input logic [14:0] param);
      synth_cmd_t c;
      c.kind  = kind;
      c.param = param;
      expected_cmds.push_back(c);
    endfunction

    function bit mapped_command(input logic [6:0] cc, output logic [4:0] cmd);
      bit hit;
      hit = 1'b1;
      case (cc)
        7'd0:    cmd = mevt_pkg::CMD_BANK;
        7'd1:    cmd = mevt_pkg::CMD_MODULATION;
        7'd5:    cmd = mevt_pkg::CMD_PORTA_TIME;
        7'd7:    cmd = mevt_pkg::CMD_VOLUME;
        7'd10:   cmd = mevt_pkg::CMD_PAN;
        7'd11:   cmd = mevt_pkg::CMD_EXPRESSION;
        7'd32:   cmd = mevt_pkg::CMD_BANK_LOW;
        7'd64:   cmd = mevt_pkg::CMD_SUSTAIN;
        7'd65:   cmd = mevt_pkg::CMD_PORTAMENTO;
        7'd66:   cmd = mevt_pkg::CMD_SOSTENUTO;
        7'd67:   cmd = mevt_pkg::CMD_SOFT;
        7'd71:   cmd = mevt_pkg::CMD_RESONANCE;
        7'd72:   cmd = mevt_pkg::CMD_RELEASE;
        7'd73:   cmd = mevt_pkg::CMD_ATTACK;
        7'd74:   cmd = mevt_pkg::CMD_CUTOFF;
        7'd75:   cmd = mevt_pkg::CMD_DECAY;
        7'd84:   cmd = mevt_pkg::CMD_PORTA_NOTE;
        7'd91:   cmd = mevt_pkg::CMD_REVERB;
        7'd93:   cmd = mevt_pkg::CMD_CHORUS;
        7'd120:  cmd = mevt_pkg::CMD_SOUND_OFF;
        7'd121:  cmd = mevt_pkg::CMD_RESET_CTRL;
        7'd123:  cmd = mevt_pkg::CMD_NOTES_OFF;
        default: begin
          cmd = mevt_pkg::CMD_CONTROL;
          hit = 1'b0;
        end
      endcase
      return hit;
    endfunction

    // Updates the selection store and queues the command this item gives, if any.
    function void note_event(input mevt_pkg::event_kind_t ev, input logic [3:0] ch,
                             input logic [13:0] a_full, input logic [6:0] b);
      logic [6:0] a;
      logic [4:0] cmd;
      a = a_full[6:0];
      case (ev)
        mevt_pkg::EV_NOTE_ON:   queue_cmd(mevt_pkg::CMD_NOTE, {b, 1'b0, a});
        mevt_pkg::EV_NOTE_OFF:  queue_cmd(mevt_pkg::CMD_NOTE, {8'd0, a});
        mevt_pkg::EV_KEY_PRES:  queue_cmd(mevt_pkg::CMD_KEYPRES, {b, 1'b0, a});
        mevt_pkg::EV_CTRL: begin
          if (a == mevt_pkg::CC_RPN_MSB || a == mevt_pkg::CC_RPN_LSB ||
              a == mevt_pkg::CC_NRPN_MSB || a == mevt_pkg::CC_NRPN_LSB) begin
            sel_kind[ch] = (a >= mevt_pkg::CC_RPN_LSB) ? mevt_pkg::SEL_REG
                                                       : mevt_pkg::SEL_NONREG;
            if (a == mevt_pkg::CC_RPN_MSB || a == mevt_pkg::CC_NRPN_MSB) sel_high[ch] = b;
            else sel_low[ch] = b;
          end else if (a == mevt_pkg::CC_DATA_ENTRY) begin
            if (sel_kind[ch] == mevt_pkg::SEL_REG && sel_high[ch] == 7'd0) begin
              case (sel_low[ch])
                mevt_pkg::RPN_PITCH_RANGE: queue_cmd(mevt_pkg::CMD_PITCHRANGE, {8'd0, b});
                mevt_pkg::RPN_FINE_TUNE:   queue_cmd(mevt_pkg::CMD_FINETUNE, {8'd0, b});
                mevt_pkg::RPN_COARSE_TUNE: queue_cmd(mevt_pkg::CMD_COARSETUNE, {8'd0, b});
                default: ;
              endcase
            end
          end else if (a != mevt_pkg::CC_DATA_LOW) begin
            if (mapped_command(a, cmd)) queue_cmd(cmd, {8'd0, b});
            else queue_cmd(mevt_pkg::CMD_CONTROL, {b, 1'b0, a});
          end
        end
        mevt_pkg::EV_PROGRAM:   queue_cmd(mevt_pkg::CMD_PROGRAM, {8'd0, a});
        mevt_pkg::EV_CHAN_PRES: queue_cmd(mevt_pkg::CMD_CHANPRES, {8'd0, a});
        mevt_pkg::EV_PITCH:     queue_cmd(mevt_pkg::CMD_PITCH, {1'b0, a_full});
        default: ;
      endcase
    endfunction

    task report(input string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_command(input logic [4:0] kind, input logic [14:0] param);
      synth_cmd_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected command kind %0d param 0x%h", kind, param));
      end else begin
        want = expected_cmds.pop_front();
        if (kind !== want.kind)
          report($sformatf("command_kind %0d, want %0d", kind, want.kind));
        if (param !== want.param)
          report($sformatf("command_param 0x%h, want 0x%h (kind %0d)", param, want.param,
                           want.kind));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mevt_pkg::event_kind_t event_kind = mevt_pkg::EV_OTHER;
  logic [3:0]            channel = '0;
  logic [13:0]           data_a = '0;
  logic [6:0]            data_b = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [4:0]            command_kind;
  logic [14:0]           command_param;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int events_sent = 0;
  int quiet_cycles = 0;

  midi_command_checker cmd_check = new();

  midi_event_translator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .event_kind    (event_kind),
    .channel       (channel),
    .data_a        (data_a),
    .data_b        (data_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_kind  (command_kind),
    .command_param (command_param)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) cmd_check.check_command(command_kind, command_param);
      if (in_valid && in_ready) cmd_check.note_event(event_kind, channel, data_a, data_b);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input mevt_pkg::event_kind_t ev, input logic [3:0] ch,
                            input logic [13:0] a, input logic [6:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    event_kind <= ev;
    channel    <= ch;
    data_a     <= a;
    data_b     <= b;
    do @(posedge clk); while (!in_ready);
    if (ev != mevt_pkg::EV_OTHER) events_sent++;
  endtask

  // Controller or note number, now and then with junk in the upper bits.
  function automatic logic [13:0] wide(input logic [6:0] low7);
    return {(($urandom_range(3) == 0) ? 7'($urandom) : 7'd0), low7};
  endfunction

  task automatic random_event();
    send_event(mevt_pkg::event_kind_t'($urandom_range(7)), 4'($urandom), 14'($urandom),
               7'($urandom));
  endtask

  // Parameter select followed by data entry on one channel, with some noise mixed in.
  task automatic param_sequence(input bit registered);
    logic [3:0] ch;
    int         entries;
    ch = 4'($urandom);
    if ($urandom_range(3) != 0)
      send_event(mevt_pkg::EV_CTRL, ch,
                 wide(registered ? mevt_pkg::CC_RPN_MSB : mevt_pkg::CC_NRPN_MSB),
                 ($urandom_range(3) == 0) ? 7'($urandom) : 7'd0);
    send_event(mevt_pkg::EV_CTRL, ch,
               wide(registered ? mevt_pkg::CC_RPN_LSB : mevt_pkg::CC_NRPN_LSB),
               ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3)));
    entries = $urandom_range(1, 3);
    repeat (entries) begin
      if ($urandom_range(4) == 0) random_event();
      send_event(mevt_pkg::EV_CTRL, ch,
                 wide(($urandom_range(5) == 0) ? mevt_pkg::CC_DATA_LOW
                                               : mevt_pkg::CC_DATA_ENTRY),
                 7'($urandom));
    end
  endtask

  task automatic random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) param_sequence(1'b1);
    else if (pick < 50) param_sequence(1'b0);
    else if (pick < 65)
      send_event(mevt_pkg::EV_CTRL, 4'($urandom), wide(7'($urandom)), 7'($urandom));
    else random_event();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmd_check.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int stop_at;
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = events_sent + count;
    while (events_sent < stop_at) random_burst();
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_event(mevt_pkg::EV_NOTE_ON, 4'd0, 14'd0, 7'd0);
    send_event(mevt_pkg::EV_NOTE_ON, 4'd15, 14'h3FFF, 7'd127);
    send_event(mevt_pkg::EV_NOTE_OFF, 4'd1, 14'h2A45, 7'd127);
    send_event(mevt_pkg::EV_KEY_PRES, 4'd2, {7'h7F, 7'd60}, 7'd100);
    send_event(mevt_pkg::EV_PROGRAM, 4'd4, 14'h3FFF, 7'd0);
    send_event(mevt_pkg::EV_CHAN_PRES, 4'd5, 14'h1F89, 7'd5);
    send_event(mevt_pkg::EV_PITCH, 4'd6, 14'h3FFF, 7'd0);
    send_event(mevt_pkg::EV_OTHER, 4'd7, 14'h3FFF, 7'd127);
    // data entry with nothing selected
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd12);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_RPN_MSB}, 7'd0);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_RPN_LSB},
               mevt_pkg::RPN_PITCH_RANGE);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd127);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_RPN_LSB},
               mevt_pkg::RPN_FINE_TUNE);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd64);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'h7F, mevt_pkg::CC_RPN_LSB},
               mevt_pkg::RPN_COARSE_TUNE);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'h55, mevt_pkg::CC_DATA_ENTRY}, 7'd1);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_RPN_LSB}, 7'd3);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd9);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_LOW}, 7'd9);
    // registered pair with nonzero high byte, then a non-registered one
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_RPN_MSB}, 7'd1);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd33);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_NRPN_MSB}, 7'd0);
    send_event(mevt_pkg::EV_CTRL, 4'd3, {7'd0, mevt_pkg::CC_DATA_ENTRY}, 7'd44);
    send_event(mevt_pkg::EV_CTRL, 4'd8, {7'd0, 7'd7}, 7'd64);
    send_event(mevt_pkg::EV_CTRL, 4'd9, {7'h7F, 7'd2}, 7'd127);
    send_event(mevt_pkg::EV_CTRL, 4'd10, {7'd0, 7'd127}, 7'd0);
    send_event(mevt_pkg::EV_CTRL, 4'd11, {7'd0, 7'd123}, 7'd127);
    wait_for_results();

    // receiver holds off at the start of the first phase so the pipe backs up
    hold_asked++;
    run_phase(0, 0, 370);
    run_phase(64, 0, 370);
    run_phase(0, 64, 370);
    run_phase(21, 21, 370);

    repeat (8) @(posedge clk);
    if (cmd_check.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mevt_pkg.sv
rtl/mevt_sel_store.sv
rtl/mevt_decode.sv
rtl/midi_event_translator.sv
rtl/mevt_checker.sv
test/testbench.sv
